>>> rtl/core/date_difference_in_days_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date difference block
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_IN_DAYS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DDD_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("date difference check failed");

// Implication with a fixed delay in cycles
`define DDD_CHECK_LAT(lbl, ante, lat, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##lat (cons)) else $error("date difference latency check failed");

`endif

>>> rtl/core/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int YEAR_LIM_W = 15;   // holds any year limit up to 32767
    localparam int DN_W       = 23;   // day number of any 14-bit year
    localparam int COUNT_W    = 22;
    localparam int PROD_W     = 27;   // 14-bit year times the reciprocal
    localparam int QUOT_W     = 8;    // year / 100 for a 14-bit year
    localparam int DIV_SHIFT  = 19;
    localparam int CUM_W      = 9;
    localparam int PART_W     = 10;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [PROD_W-1:0]  DIV100_MUL = PROD_W'(5243);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DN_W-1:0] dn;
        logic            ok;
    } t_date_res;

    // Days of the month, February depends on the leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the start of a month, months counted from March
    function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] ma);
        logic [CUM_W-1:0] cum;
        case (ma)
            4'd0:    cum = 9'd0;
            4'd1:    cum = 9'd31;
            4'd2:    cum = 9'd61;
            4'd3:    cum = 9'd92;
            4'd4:    cum = 9'd122;
            4'd5:    cum = 9'd153;
            4'd6:    cum = 9'd184;
            4'd7:    cum = 9'd214;
            4'd8:    cum = 9'd245;
            4'd9:    cum = 9'd275;
            4'd10:   cum = 9'd306;
            4'd11:   cum = 9'd337;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ddd_date_unit.sv
// ----------------------------------------------------------------------------
// ddd_date_unit
// Three-stage conversion of one calendar date into a day number, with a
// check that the date exists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddd_date_unit #(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic                        i_clk,
    input  wire logic [ddd_pkg::YEAR_W-1:0]  i_year,
    input  wire logic [ddd_pkg::MONTH_W-1:0] i_month,
    input  wire logic [ddd_pkg::DAY_W-1:0]   i_day,
    output ddd_pkg::t_date_res               o_res
);
    import ddd_pkg::*;

    localparam logic [YEAR_LIM_W-1:0] MaxYearW = YEAR_LIM_W'(MAX_YEAR);

    // stage 1: shifted year, March-based month, reciprocal products
    logic [YEAR_W-1:0]  r1_y, r1_ya, n1_ya;
    logic [MONTH_W-1:0] r1_m, r1_ma, n1_ma;
    logic [DAY_W-1:0]   r1_d;
    logic               r1_rng, n1_rng;
    logic [PROD_W-1:0]  r1_py, r1_pya;

    always_comb begin
        n1_ya  = (i_month <= 4'd2) ? i_year - 14'd1 : i_year;
        n1_ma  = (i_month >= 4'd3) ? i_month - 4'd3 : i_month + 4'd9;
        n1_rng = (i_year != '0) && ({1'b0, i_year} <= MaxYearW)
              && (i_month >= 4'd1) && (i_month <= 4'd12) && (i_day != '0);
    end

    always_ff @(posedge i_clk) begin
        r1_y   <= i_year;
        r1_m   <= i_month;
        r1_d   <= i_day;
        r1_ya  <= n1_ya;
        r1_ma  <= n1_ma;
        r1_rng <= n1_rng;
        r1_py  <= PROD_W'(i_year) * DIV100_MUL;
        r1_pya <= PROD_W'(n1_ya) * DIV100_MUL;
    end

    // stage 2: leap rule, day-of-month check, two partial sums
    logic [QUOT_W-1:0] q_y, q_ya;
    logic              leap;
    logic              r2_ok, n2_ok;
    logic [DN_W-1:0]   r2_s1, n2_s1;
    logic [PART_W-1:0] r2_s2, n2_s2;

    always_comb begin
        q_y   = r1_py[DIV_SHIFT +: QUOT_W];
        q_ya  = r1_pya[DIV_SHIFT +: QUOT_W];
        // divisible by 4, and either not by 100 or by 400
        leap  = (r1_y[1:0] == 2'd0)
             && ((r1_y != YEAR_W'(q_y) * YEAR_W'(100)) || (q_y[1:0] == 2'd0));
        n2_ok = r1_rng && (r1_d <= month_len(r1_m, leap));
        n2_s1 = DN_W'(r1_ya) * DN_W'(365) + DN_W'(r1_ya >> 2) - DN_W'(q_ya);
        n2_s2 = PART_W'(days_before(r1_ma)) + PART_W'(r1_d) + PART_W'(q_ya >> 2);
    end

    always_ff @(posedge i_clk) begin
        r2_ok <= n2_ok;
        r2_s1 <= n2_s1;
        r2_s2 <= n2_s2;
    end

    // stage 3: final day number
    t_date_res r3_res;

    always_ff @(posedge i_clk) begin
        r3_res.dn <= r2_s1 + DN_W'(r2_s2);
        r3_res.ok <= r2_ok;
    end

    assign o_res = r3_res;

endmodule

`default_nettype wire

>>> rtl/core/ddd_diff.sv
// ----------------------------------------------------------------------------
// ddd_diff
// Two-stage subtraction of day numbers, end-day adjust and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddd_diff (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic                          i_inc,
    input  wire ddd_pkg::t_date_res            i_start,
    input  wire ddd_pkg::t_date_res            i_end,
    output logic                               o_strobe,
    output logic [ddd_pkg::COUNT_W-1:0]        o_day_count,
    output logic                               o_dates_valid
);
    import ddd_pkg::*;

    // stage 1: difference and order
    logic            r_vld, r_inc, r_gt, r_ok;
    logic [DN_W-1:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_inc  <= i_inc;
        r_gt   <= i_start.dn < i_end.dn;
        r_ok   <= i_start.ok & i_end.ok;
        r_diff <= i_end.dn - i_start.dn;
    end

    // stage 2: add the end day, clamp, drop invalid dates to zero
    logic [DN_W:0]      n_sum;
    logic [COUNT_W-1:0] n_count;
    logic               r_strobe, r_valid;
    logic [COUNT_W-1:0] r_count;

    always_comb begin
        n_sum = (r_gt ? {1'b0, r_diff} : '0) + (DN_W+1)'(r_inc);
        if (!r_ok) begin
            n_count = '0;
        end else if (n_sum > (DN_W+1)'(COUNT_MAX)) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = n_sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld;
        end
        r_count <= n_count;
        r_valid <= r_ok;
    end

    assign o_strobe      = r_strobe;
    assign o_day_count   = r_count;
    assign o_dates_valid = r_valid;

endmodule

`default_nettype wire

>>> rtl/core/date_difference_in_days.sv
// ----------------------------------------------------------------------------
// date_difference_in_days
// Days between two proleptic Gregorian dates, one transaction per cycle.
//
//   Channel   Direction  Handshake                Payload
//   command   in         start && !busy           i_start_*, i_end_*, i_include_end
//   result    out        o_strobe, one cycle      o_day_count, o_dates_valid
//
// A transaction is taken on any cycle; busy is high only while in reset.
// Each transaction passes three stages of date conversion (reciprocal multiply for the
// century term, leap check, day number), then two of subtract and clamp, and the strobe
// is registered alongside the result.
// Synchronous active-low reset clears only the valid and strobe bits, not o_dates_valid.
// Results cannot be held off; the pipeline never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "date_difference_in_days_macros.svh"

module date_difference_in_days #(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ddd_pkg::YEAR_W-1:0]  i_start_year,
    input  wire logic [ddd_pkg::MONTH_W-1:0] i_start_month,
    input  wire logic [ddd_pkg::DAY_W-1:0]   i_start_day,
    input  wire logic [ddd_pkg::YEAR_W-1:0]  i_end_year,
    input  wire logic [ddd_pkg::MONTH_W-1:0] i_end_month,
    input  wire logic [ddd_pkg::DAY_W-1:0]   i_end_day,
    input  wire logic                        i_include_end,
    output logic                             o_strobe,
    output logic [ddd_pkg::COUNT_W-1:0]      o_day_count,
    output logic                             o_dates_valid
);
    import ddd_pkg::*;

    localparam int CONV_STAGES = 3;

    t_date_res                s_res, e_res;
    logic [CONV_STAGES-1:0]   r_vld, r_inc;
    logic                     accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    ddd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_start (
        .i_clk   (i_clk),
        .i_year  (i_start_year),
        .i_month (i_start_month),
        .i_day   (i_start_day),
        .o_res   (s_res)
    );

    ddd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_end (
        .i_clk   (i_clk),
        .i_year  (i_end_year),
        .i_month (i_end_month),
        .i_day   (i_end_day),
        .o_res   (e_res)
    );

    // carry valid and the end-day flag alongside the conversion stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CONV_STAGES-2:0], accept};
        end
        r_inc <= {r_inc[CONV_STAGES-2:0], i_include_end};
    end

    ddd_diff u_diff (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_vld[CONV_STAGES-1]),
        .i_inc         (r_inc[CONV_STAGES-1]),
        .i_start       (s_res),
        .i_end         (e_res),
        .o_strobe      (o_strobe),
        .o_day_count   (o_day_count),
        .o_dates_valid (o_dates_valid)
    );

    `DDD_CHECK(a_invalid_zero, o_strobe && !o_dates_valid, o_day_count == '0)
    `DDD_CHECK_LAT(a_latency, accept, 5, o_strobe)
    `DDD_CHECK(a_no_spurious, o_strobe, $past(r_vld[CONV_STAGES-1], 2))

endmodule

`default_nettype wire
